@@ design/dqne_pkg.sv @@
// dqne_pkg: shared types and constants for the DNS query name extractor.
// No dependencies; every other design file depends on it.
package dqne_pkg;

   localparam int DEFAULT_MAX_NAME_BYTES = 256;
   localparam int DEFAULT_QUEUE_DEPTH    = 4;
   localparam int CSR_W                  = 9;
   localparam logic [CSR_W-1:0] CSR_RESET = 9'd256;

   localparam int HDR_BYTES  = 12;
   localparam int LABEL_MAX  = 63;
   localparam logic [7:0] PTR_MASK    = 8'hC0;
   localparam logic [7:0] PERIOD_CHAR = 8'h2E;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] len16_type;
   typedef logic [2:0]  status_type;

   localparam status_type STAT_COMPLETE    = 3'd0;
   localparam status_type STAT_POINTER     = 3'd1;
   localparam status_type STAT_BAD_LABEL   = 3'd2;
   localparam status_type STAT_TRUNCATED   = 3'd3;
   localparam status_type STAT_PAYLOAD_END = 3'd4;
   localparam status_type STAT_SHORT       = 3'd5;
   localparam status_type STAT_NO_QUESTION = 3'd6;

   // one queued work item: an optional character, an optional closing result
   typedef struct packed {
      logic       has_char;
      byte_type   ch;
      logic       has_final;
      status_type status;
      byte_type   name_len;
   } work_item_type;

endpackage

@@ design/dqne_req_if.sv @@
// dqne_req_if: input byte channel (valid/ready plus message byte fields).
// Depends on dqne_pkg.
interface dqne_req_if;
   logic                valid;
   logic                ready;
   dqne_pkg::byte_type  data_byte;
   logic                first_byte;
   dqne_pkg::len16_type packet_length;

   modport source (output valid, output data_byte, output first_byte, output packet_length,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input packet_length,
                   output ready);
endinterface

@@ design/dqne_rsp_if.sv @@
// dqne_rsp_if: result channel (valid/ready plus character and status fields).
// Depends on dqne_pkg.
interface dqne_rsp_if;
   logic                 valid;
   logic                 ready;
   dqne_pkg::byte_type   name_char;
   logic                 is_final;
   dqne_pkg::status_type status;
   dqne_pkg::byte_type   name_length;

   modport source (output valid, output name_char, output is_final, output status,
                   output name_length, input ready);
   modport sink   (input valid, input name_char, input is_final, input status,
                   input name_length, output ready);
endinterface

@@ design/dqne_parser.sv @@
// dqne_parser: front end. Tracks header/label state per accepted beat and
// builds one work item per beat that produces results. Depends on dqne_pkg.
module dqne_parser #(
   parameter int MAX_NAME_BYTES = dqne_pkg::DEFAULT_MAX_NAME_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  dqne_pkg::byte_type        data_byte,
   input  logic                      first_byte,
   input  dqne_pkg::len16_type       packet_length,
   input  logic                      csr_wr_en,
   input  logic [dqne_pkg::CSR_W-1:0] csr_wr_data,
   output logic                      push,
   output dqne_pkg::work_item_type   item
);
   import dqne_pkg::*;

   localparam int CW = $clog2(MAX_NAME_BYTES);
   localparam int SW = ($clog2(MAX_NAME_BYTES + 1) > CSR_W) ? $clog2(MAX_NAME_BYTES + 1)
                                                              : CSR_W;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   logic [CSR_W-1:0] cfg_ff;
   logic [2:0]       phase_ff, phase_in;
   len16_type        pos_ff, pos_in;
   len16_type        mlen_ff, mlen_in;
   byte_type         qhi_ff, qhi_in;
   logic [5:0]       left_ff, left_in;
   logic [CW-1:0]    chars_ff, chars_in;
   logic             period_ff, period_in;

   logic [SW-1:0]    cfg_ext;
   logic [CW-1:0]    lim;

   // 0 acts as 1, anything above the build size acts as the build size
   always_comb begin
      cfg_ext = SW'(cfg_ff);
      if (cfg_ext == '0) begin
         lim = '0;
      end else if (cfg_ext > SW'(MAX_NAME_BYTES)) begin
         lim = CW'(MAX_NAME_BYTES - 1);
      end else begin
         lim = CW'(cfg_ext - SW'(1));
      end
   end

   always_comb begin
      logic             skip;
      logic             fin;
      logic             has_c;
      byte_type         c;
      status_type       st;
      len16_type        p;
      logic [16:0]      pos_next17;
      logic [16:0]      label_end;

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      mlen_in   = mlen_ff;
      qhi_in    = qhi_ff;
      left_in   = left_ff;
      chars_in  = chars_ff;
      period_in = period_ff;
      skip      = 1'b0;
      fin       = 1'b0;
      has_c     = 1'b0;
      c         = '0;
      st        = STAT_COMPLETE;
      p         = '0;

      if (first_byte) begin
         mlen_in   = packet_length;
         pos_in    = '0;
         qhi_in    = '0;
         left_in   = '0;
         chars_in  = '0;
         period_in = 1'b0;
         phase_in  = PH_HEADER;
         if (packet_length < 16'(HDR_BYTES)) begin
            fin  = 1'b1;
            st   = STAT_SHORT;
            skip = 1'b1;
         end
      end

      pos_next17 = 17'(pos_in) + 17'd1;
      label_end  = pos_next17 + 17'(data_byte);

      if (!skip && phase_in != PH_IDLE && phase_in != PH_DONE) begin
         p      = pos_in;
         pos_in = p + 16'd1;
         unique case (phase_in)
            PH_HEADER: begin
               if (p == 16'd4) qhi_in = data_byte;
               if (p == 16'd5 && qhi_in == '0 && data_byte == '0) begin
                  fin = 1'b1;
                  st  = STAT_NO_QUESTION;
               end else if (p >= 16'(HDR_BYTES - 1)) begin
                  if (mlen_in == 16'(HDR_BYTES)) begin
                     fin = 1'b1;
                     st  = STAT_PAYLOAD_END;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               priority if (data_byte == '0) begin
                  fin = 1'b1;
                  st  = STAT_COMPLETE;
               end else if ((data_byte & PTR_MASK) == PTR_MASK) begin
                  fin = 1'b1;
                  st  = STAT_POINTER;
               end else if (data_byte > 8'(LABEL_MAX)) begin
                  fin = 1'b1;
                  st  = STAT_BAD_LABEL;
               end else if (label_end > 17'(mlen_in)) begin
                  fin = 1'b1;
                  st  = STAT_PAYLOAD_END;
               end else begin
                  if (period_in && chars_in < lim) begin
                     has_c    = 1'b1;
                     c        = PERIOD_CHAR;
                     chars_in = chars_in + CW'(1);
                  end
                  period_in = 1'b1;
                  if (chars_in >= lim) begin
                     fin = 1'b1;
                     st  = STAT_TRUNCATED;
                  end else begin
                     left_in  = data_byte[5:0];
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               has_c    = 1'b1;
               c        = data_byte;
               chars_in = chars_in + CW'(1);
               left_in  = left_in - 6'd1;
               if (left_in != '0) begin
                  if (chars_in >= lim) begin
                     fin = 1'b1;
                     st  = STAT_TRUNCATED;
                  end
               end else begin
                  phase_in = PH_LEN;
                  if (pos_next17 >= 17'(mlen_in)) begin
                     fin = 1'b1;
                     st  = STAT_PAYLOAD_END;
                  end
               end
            end
            default: ;
         endcase
      end

      if (fin) phase_in = PH_DONE;

      push           = accept && (has_c || fin);
      item.has_char  = has_c;
      item.ch        = c;
      item.has_final = fin;
      item.status    = st;
      item.name_len  = (32'(chars_in) > 32'd255) ? 8'd255 : 8'(chars_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= CSR_RESET;
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         mlen_ff   <= '0;
         qhi_ff    <= '0;
         left_ff   <= '0;
         chars_ff  <= '0;
         period_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cfg_ff <= csr_wr_data;
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            mlen_ff   <= mlen_in;
            qhi_ff    <= qhi_in;
            left_ff   <= left_in;
            chars_ff  <= chars_in;
            period_ff <= period_in;
         end
      end
   end

endmodule

@@ design/dqne_queue.sv @@
// dqne_queue: small FIFO of work items between parser and emitter.
// Depends on dqne_pkg.
module dqne_queue #(
   parameter int DEPTH = dqne_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dqne_pkg::work_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output dqne_pkg::work_item_type head_item
);
   import dqne_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   work_item_type   mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == NW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + NW'(1);
      if (do_pop && !do_push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

endmodule

@@ design/dqne_emitter.sv @@
// dqne_emitter: back end. Splits a work item into its character beat and
// closing beat on the result channel. Depends on dqne_pkg.
module dqne_emitter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  dqne_pkg::work_item_type head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dqne_pkg::byte_type      rsp_name_char,
   output logic                    rsp_is_final,
   output dqne_pkg::status_type    rsp_status,
   output dqne_pkg::byte_type      rsp_name_length
);
   import dqne_pkg::*;

   logic char_done_ff, char_done_in;
   logic char_part;
   logic last_part;
   logic fire;

   assign char_part = head_item.has_char && !char_done_ff;
   assign last_part = !char_part || !head_item.has_final;
   assign fire      = head_valid && rsp_ready;
   assign pop       = fire && last_part;

   assign rsp_valid       = head_valid;
   assign rsp_name_char   = char_part ? head_item.ch : '0;
   assign rsp_is_final    = !char_part;
   assign rsp_status      = char_part ? STAT_COMPLETE : head_item.status;
   assign rsp_name_length = head_item.name_len;

   // remembers that the character of a two-beat item already went out
   always_comb begin
      char_done_in = char_done_ff;
      if (fire) char_done_in = !last_part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_done_ff <= 1'b0;
      end else begin
         char_done_ff <= char_done_in;
      end
   end

endmodule

@@ design/dns_query_name_extractor.sv @@
// Results of an accepted beat are written into the work-item queue and appear on rsp
// from its head. One input beat per cycle while the queue is not full; a beat that yields
// a character and the closing result takes two result beats, absorbed by the queue.
// req ready drops only when the work-item queue is full.
// Reset is synchronous, active high: parse state and queue clear, the output
// buffer size register returns to 256.
module dns_query_name_extractor #(
   parameter int MAX_NAME_BYTES = dqne_pkg::DEFAULT_MAX_NAME_BYTES,
   parameter int QUEUE_DEPTH    = dqne_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   dqne_req_if.sink                   req_bus,
   dqne_rsp_if.source                 rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [dqne_pkg::CSR_W-1:0] csr_wr_data
);
   import dqne_pkg::*;

   logic          accept;
   logic          push;
   logic          full;
   logic          pop;
   logic          head_valid;
   work_item_type push_item;
   work_item_type head_item;

   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && !full;

   dqne_parser #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_bus.data_byte),
      .first_byte    (req_bus.first_byte),
      .packet_length (req_bus.packet_length),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .push          (push),
      .item          (push_item)
   );

   dqne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   dqne_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_name_char   (rsp_bus.name_char),
      .rsp_is_final    (rsp_bus.is_final),
      .rsp_status      (rsp_bus.status),
      .rsp_name_length (rsp_bus.name_length)
   );

endmodule

@@ design/dqne_checker.sv @@
// dqne_checker: port-level assertions for dns_query_name_extractor, attached by bind.
// Depends on dqne_pkg.
module dqne_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dqne_pkg::byte_type   name_char,
   input logic                 is_final,
   input dqne_pkg::status_type status,
   input dqne_pkg::byte_type   name_length
);
   import dqne_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({name_char, is_final, status, name_length}))
      else $error("stalled result beat changed");

   a_char_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_final |-> status == STAT_COMPLETE && name_length != '0)
      else $error("character beat with status or zero length");

   a_final_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_final |-> name_char == '0 && status <= STAT_NO_QUESTION)
      else $error("closing beat with character or bad status");

endmodule

bind dns_query_name_extractor dqne_checker u_dqne_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .name_char   (rsp_bus.name_char),
   .is_final    (rsp_bus.is_final),
   .status      (rsp_bus.status),
   .name_length (rsp_bus.name_length)
);
